### hdl/tdmg_pkg.sv
// shared types and constants of the temporal depth median gate
package tdmg_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int DEPTH_W    = 16;
	localparam int RANK_W     = 3;
	localparam int CFG_IDX_W  = 8;

	typedef logic [DEPTH_W-1:0]   depth_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MIN_DEPTH = cfg_idx_t'(0);
	localparam cfg_idx_t REG_MAX_DEPTH = cfg_idx_t'(1);

	// one lane's finding: its own sample and where it lands in sorted order
	typedef struct packed {
		rank_t  rank;
		depth_t sample;
	} lane_res_t;

endpackage

### hdl/tdmg_lane.sv
// one rank lane: places its own sample among all active samples
module tdmg_lane
	import tdmg_pkg::*;
#(
	parameter int FRAME_COUNT = 8,
	parameter int LANE        = 0
) (
	input  depth_t    samples [MAX_FRAMES],
	output lane_res_t res
);

	rank_t cnt;

	// stable rank: ties are broken by frame number
	always_comb begin
		cnt = '0;
		for (int j = 0; j < FRAME_COUNT; j++) begin
			if (j != LANE) begin
				if ((samples[j] < samples[LANE]) ||
				    ((samples[j] == samples[LANE]) && (j < LANE))) begin
					cnt = cnt + rank_t'(1);
				end
			end
		end
	end

	assign res.rank   = cnt;
	assign res.sample = samples[LANE];

endmodule

### hdl/tdmg_merge.sv
// merge stage: picks the lane holding the median and applies the depth window
module tdmg_merge
	import tdmg_pkg::*;
#(
	parameter int FRAME_COUNT = 8
) (
	input  lane_res_t lanes [MAX_FRAMES],
	input  depth_t    min_depth,
	input  depth_t    max_depth,
	output depth_t    result
);

	localparam rank_t MED_RANK = rank_t'(FRAME_COUNT / 2);

	depth_t median;

	// ranks are a permutation, so exactly one lane matches
	always_comb begin
		median = '0;
		for (int i = 0; i < FRAME_COUNT; i++) begin
			if (lanes[i].rank == MED_RANK) begin
				median = median | lanes[i].sample;
			end
		end
	end

	assign result = ((median < min_depth) || (median > max_depth)) ? '0 : median;

endmodule

### hdl/temporal_depth_median_gate.sv
// top level of the temporal depth median gate: lanes, merge, pipeline and config registers
//
// Temporal median gate for depth pixels. Each transfer on the input channel carries the
// samples of one pixel position from FRAME_COUNT aligned frames (depth_0 upwards; higher
// fields are ignored). The block returns, one transfer per input, the sample at sorted
// index FRAME_COUNT/2 (the upper median for an even count), or zero when that value lies
// outside the inclusive window [min_depth, max_depth]. It takes one item every clock and
// is pipelined: stage one is a row of rank lanes, one per frame, each comparing
// its sample with all the others; stage two is the merge that selects the lane of
// median rank and applies the window. The rate is set by that combinational compare
// network, so the block sustains one item per cycle whenever the output is not stalled.
// Config registers: index 0 is min_depth (reset 0), index 1 is max_depth (reset 65535);
// other indexes are ignored. Writes are always taken and should only be issued while the
// block holds no item.
module temporal_depth_median_gate
	import tdmg_pkg::*;
#(
	parameter int FRAME_COUNT = 8
) (
	input  logic     clk,
	input  logic     arst_n,

	input  logic     in_valid,
	output logic     in_stall,
	input  depth_t   depth_0,
	input  depth_t   depth_1,
	input  depth_t   depth_2,
	input  depth_t   depth_3,
	input  depth_t   depth_4,
	input  depth_t   depth_5,
	input  depth_t   depth_6,
	input  depth_t   depth_7,

	output logic     out_valid,
	input  logic     out_stall,
	output depth_t   filtered_depth,

	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  depth_t   cfg_data
);

	// gather the frame samples into one vector for the lanes
	depth_t    samples [MAX_FRAMES];
	lane_res_t lane_res [MAX_FRAMES];
	lane_res_t lane_res_s1 [MAX_FRAMES];
	logic      valid_s1;
	logic      valid_s2;
	depth_t    result_s2;
	depth_t    merged;
	depth_t    min_q;
	depth_t    max_q;
	logic      adv_s1;
	logic      adv_s2;
	logic [MAX_FRAMES-1:0] med_hit;

	assign samples[0] = depth_0;
	assign samples[1] = depth_1;
	assign samples[2] = depth_2;
	assign samples[3] = depth_3;
	assign samples[4] = depth_4;
	assign samples[5] = depth_5;
	assign samples[6] = depth_6;
	assign samples[7] = depth_7;

	// rank lanes, one per active frame; idle lanes are tied off
	for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_lane
		if (g < FRAME_COUNT) begin : g_on
			tdmg_lane #(
				.FRAME_COUNT (FRAME_COUNT),
				.LANE        (g)
			) u_lane (
				.samples (samples),
				.res     (lane_res[g])
			);
		end else begin : g_off
			assign lane_res[g] = '0;
		end
	end

	// pipeline flow: a stage loads when it is empty or its contents move on
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload of lane stage
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			lane_res_s1 <= lane_res;
		end
	end

	tdmg_merge #(
		.FRAME_COUNT (FRAME_COUNT)
	) u_merge (
		.lanes     (lane_res_s1),
		.min_depth (min_q),
		.max_depth (max_q),
		.result    (merged)
	);

	// output register doubles as the skid stage
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= merged;
		end
	end

	assign out_valid      = valid_s2;
	assign filtered_depth = result_s2;

	// config registers, written on any transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_DEPTH: min_q <= cfg_data;
				REG_MAX_DEPTH: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// which lanes claim the median rank, for checking only
	always_comb begin
		med_hit = '0;
		for (int i = 0; i < FRAME_COUNT; i++) begin
			med_hit[i] = (lane_res_s1[i].rank == rank_t'(FRAME_COUNT / 2));
		end
	end

	// stall only when both stages are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while pipeline has room");

	// an accepted item reaches the lane stage
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted item lost before lane stage");

	// an item in the lane stage moves on to the output when allowed
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("lane stage item lost before output");

	// the lane ranks form a permutation: one median lane exactly
	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot(med_hit))
		else $error("median rank claimed by zero or several lanes");

endmodule
